>>> hw/rtl/pts_pkg.sv
// pts_pkg: shared types, constants and note ROM for the tone sequencer.
// Used by pts_div, pts_dp, pts_ctrl and pwm_tone_sequencer.
package pts_pkg;

	localparam int PATTERN_COUNT     = 8;
	localparam int NOTES_PER_PATTERN = 8;
	localparam int PERIOD_WIDTH_DEF  = 24;

	localparam int ROM_ROWS   = 8;
	localparam int ROM_COLS   = 8;
	localparam int PAT_W      = 3;
	localparam int NOTE_W     = 3;
	localparam int NOTE_IDX_W = 4;
	localparam int RATE_W     = 20;
	localparam int FREQ_W     = 11;
	localparam int DUR_W      = 9;
	localparam int TGT_W      = 16;
	localparam int DND_W      = DUR_W + RATE_W;
	localparam int DVS_W      = FREQ_W;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(375000);
	localparam logic [FREQ_W-1:0] MS_PER_S   = FREQ_W'(1000);
	localparam logic [FREQ_W-1:0] FREQ_END   = FREQ_W'(0);
	localparam logic [FREQ_W-1:0] FREQ_REST  = FREQ_W'(1);

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIVIDE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic fetch;
		logic load;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_load;
		logic note_end;
		logic div_done;
	} dp_status_t;

	localparam logic [FREQ_W-1:0] ROM_FREQ [ROM_ROWS][ROM_COLS] = '{
		'{11'd880,  11'd1, 11'd1110, 11'd1,   11'd1320, 11'd1,   11'd1760, 11'd0},
		'{11'd1760, 11'd1, 11'd1320, 11'd1,   11'd1110, 11'd1,   11'd880,  11'd0},
		'{11'd760,  11'd1, 11'd760,  11'd0,   11'd0,    11'd0,   11'd0,    11'd0},
		'{11'd880,  11'd1, 11'd587,  11'd0,   11'd0,    11'd0,   11'd0,    11'd0},
		'{11'd1047, 11'd1, 11'd1047, 11'd830, 11'd1,    11'd880, 11'd698,  11'd0},
		'{11'd1047, 11'd0, 11'd0,    11'd0,   11'd0,    11'd0,   11'd0,    11'd0},
		'{11'd1047, 11'd1, 11'd1047, 11'd0,   11'd0,    11'd0,   11'd0,    11'd0},
		'{11'd1047, 11'd1, 11'd1047, 11'd1,   11'd1047, 11'd0,   11'd0,    11'd0}
	};

	localparam logic [DUR_W-1:0] ROM_DUR [ROM_ROWS][ROM_COLS] = '{
		'{9'd100, 9'd10,  9'd100, 9'd10,  9'd100, 9'd10,  9'd100, 9'd0},
		'{9'd100, 9'd10,  9'd100, 9'd10,  9'd100, 9'd10,  9'd100, 9'd0},
		'{9'd100, 9'd100, 9'd400, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
		'{9'd300, 9'd100, 9'd500, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
		'{9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd200, 9'd0},
		'{9'd500, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
		'{9'd150, 9'd100, 9'd500, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
		'{9'd150, 9'd50,  9'd150, 9'd50,  9'd500, 9'd0,   9'd0,   9'd0}
	};

	// periods per note: max(1, dur*freq/1000); 0 at the pattern end
	localparam logic [TGT_W-1:0] ROM_TGT [ROM_ROWS][ROM_COLS] = '{
		'{16'd88,  16'd1, 16'd111, 16'd1,  16'd132, 16'd1,  16'd176, 16'd0},
		'{16'd176, 16'd1, 16'd132, 16'd1,  16'd111, 16'd1,  16'd88,  16'd0},
		'{16'd76,  16'd1, 16'd304, 16'd0,  16'd0,   16'd0,  16'd0,   16'd0},
		'{16'd264, 16'd1, 16'd293, 16'd0,  16'd0,   16'd0,  16'd0,   16'd0},
		'{16'd104, 16'd1, 16'd104, 16'd83, 16'd1,   16'd88, 16'd139, 16'd0},
		'{16'd523, 16'd0, 16'd0,   16'd0,  16'd0,   16'd0,  16'd0,   16'd0},
		'{16'd157, 16'd1, 16'd523, 16'd0,  16'd0,   16'd0,  16'd0,   16'd0},
		'{16'd157, 16'd1, 16'd157, 16'd1,  16'd523, 16'd0,  16'd0,   16'd0}
	};

	function automatic logic rom_ok(input logic [PAT_W-1:0] pat,
		input logic [NOTE_IDX_W-1:0] idx);
		return (int'(pat) < PATTERN_COUNT) && (int'(idx) < NOTES_PER_PATTERN) &&
			(int'(idx) < ROM_COLS);
	endfunction

	function automatic logic [FREQ_W-1:0] rom_freq(input logic [PAT_W-1:0] pat,
		input logic [NOTE_IDX_W-1:0] idx);
		return rom_ok(pat, idx) ? ROM_FREQ[pat][idx[NOTE_W-1:0]] : FREQ_END;
	endfunction

	function automatic logic [DUR_W-1:0] rom_dur(input logic [PAT_W-1:0] pat,
		input logic [NOTE_IDX_W-1:0] idx);
		return rom_ok(pat, idx) ? ROM_DUR[pat][idx[NOTE_W-1:0]] : '0;
	endfunction

	function automatic logic [TGT_W-1:0] rom_tgt(input logic [PAT_W-1:0] pat,
		input logic [NOTE_IDX_W-1:0] idx);
		return rom_ok(pat, idx) ? ROM_TGT[pat][idx[NOTE_W-1:0]] : '0;
	endfunction

endpackage

>>> hw/rtl/pts_div.sv
// pts_div: iterative restoring divider, one quotient bit per cycle.
// Depends on pts_pkg for default widths.
module pts_div #(
	parameter int DND_W = pts_pkg::DND_W,
	parameter int DVS_W = pts_pkg::DVS_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DND_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DND_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DND_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DND_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             fits;

	assign shifted = {rem_q, quo_q[DND_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
				quo_q <= {quo_q[DND_W-2:0], fits};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hw/rtl/pts_dp.sv
// pts_dp: sequencer datapath - rate register, note state, phase counter,
// period setup through pts_div, and the result register. Depends on pts_pkg.
module pts_dp #(
	parameter int PERIOD_WIDTH = pts_pkg::PERIOD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pts_pkg::RATE_W-1:0]   cfg_wdata,
	input  logic                         opcode,
	input  logic [pts_pkg::PAT_W-1:0]    pattern_select,
	input  pts_pkg::dp_cmd_t             cmd,
	output pts_pkg::dp_status_t          status,
	output logic                         pin_level,
	output logic                         busy_res,
	output logic [pts_pkg::NOTE_W-1:0]   note_position
);
	import pts_pkg::*;

	localparam int SAT_W = 33;

	logic [RATE_W-1:0]       rate_q;
	logic                    playing_q;
	logic [PAT_W-1:0]        pat_q;
	logic [NOTE_W-1:0]       note_idx_q;
	logic [NOTE_IDX_W-1:0]   ld_idx_q;
	logic [PERIOD_WIDTH-1:0] period_q;
	logic [PERIOD_WIDTH-1:0] high_q;
	logic [PERIOD_WIDTH-1:0] phase_q;
	logic [TGT_W-1:0]        done_q;
	logic [TGT_W-1:0]        target_q;
	logic                    rest_q;
	logic [TGT_W-1:0]        tgt_ld_q;
	logic                    pin_q;
	logic                    busy_q;
	logic [NOTE_W-1:0]       pos_q;

	logic [PERIOD_WIDTH:0]   phase_inc;
	logic                    wrap;
	logic [TGT_W-1:0]        done_inc;
	logic                    last_period;
	logic [FREQ_W-1:0]       rom_f;
	logic [DUR_W-1:0]        rom_d;
	logic [TGT_W-1:0]        rom_t;
	logic [DND_W-1:0]        product;
	logic [DND_W-1:0]        div_dividend;
	logic [DVS_W-1:0]        div_divisor;
	logic                    div_start;
	logic                    div_busy;
	logic                    div_done;
	logic [DND_W-1:0]        div_quo;
	logic [SAT_W-1:0]        quo_ext;
	logic [SAT_W-1:0]        per_max;
	logic [PERIOD_WIDTH-1:0] per_sat;

	assign phase_inc   = {1'b0, phase_q} + (PERIOD_WIDTH + 1)'(1);
	assign wrap        = phase_inc >= {1'b0, period_q};
	assign done_inc    = done_q + TGT_W'(1);
	assign last_period = done_inc >= target_q;

	assign rom_f = rom_freq(pat_q, ld_idx_q);
	assign rom_d = rom_dur(pat_q, ld_idx_q);
	assign rom_t = rom_tgt(pat_q, ld_idx_q);

	assign product      = DND_W'(rom_d) * DND_W'(rate_q);
	assign div_dividend = (rom_f == FREQ_REST) ? product : DND_W'(rate_q);
	assign div_divisor  = (rom_f == FREQ_REST) ? MS_PER_S : rom_f;
	assign div_start    = cmd.fetch && (rom_f != FREQ_END);

	pts_div #(
		.DND_W (DND_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign quo_ext = SAT_W'(div_quo);
	assign per_max = (SAT_W'(1) << PERIOD_WIDTH) - SAT_W'(1);
	assign per_sat = (quo_ext > per_max) ? per_max[PERIOD_WIDTH-1:0]
		: quo_ext[PERIOD_WIDTH-1:0];

	always_comb begin
		status.need_load = (opcode == OP_START) ? !playing_q
			: (playing_q && wrap && last_period);
		status.note_end  = (rom_f == FREQ_END);
		status.div_done  = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= RATE_RESET;
			playing_q  <= 1'b0;
			pat_q      <= '0;
			note_idx_q <= '0;
			ld_idx_q   <= '0;
			period_q   <= '0;
			high_q     <= '0;
			phase_q    <= '0;
			done_q     <= '0;
			target_q   <= '0;
			rest_q     <= 1'b0;
			tgt_ld_q   <= '0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				if (opcode == OP_START) begin
					if (!playing_q) begin
						pat_q    <= pattern_select;
						ld_idx_q <= '0;
					end
				end else if (playing_q) begin
					if (wrap) begin
						phase_q <= '0;
						done_q  <= done_inc;
						if (last_period) begin
							ld_idx_q <= {1'b0, note_idx_q} + NOTE_IDX_W'(1);
						end
					end else begin
						phase_q <= phase_inc[PERIOD_WIDTH-1:0];
					end
				end
			end
			if (cmd.fetch) begin
				if (rom_f == FREQ_END) begin
					playing_q  <= 1'b0;
					note_idx_q <= '0;
					period_q   <= '0;
					high_q     <= '0;
					phase_q    <= '0;
					done_q     <= '0;
					target_q   <= '0;
				end else begin
					rest_q   <= (rom_f == FREQ_REST);
					tgt_ld_q <= rom_t;
				end
			end
			if (cmd.load) begin
				period_q   <= per_sat;
				high_q     <= rest_q ? '0 : (per_sat >> 1);
				target_q   <= tgt_ld_q;
				done_q     <= '0;
				phase_q    <= '0;
				note_idx_q <= ld_idx_q[NOTE_W-1:0];
				playing_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q  <= 1'b0;
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (cmd.emit) begin
			pin_q  <= playing_q && (phase_q < high_q);
			busy_q <= playing_q;
			pos_q  <= playing_q ? note_idx_q : '0;
		end
	end

	assign pin_level     = pin_q;
	assign busy_res      = busy_q;
	assign note_position = pos_q;

	a_target_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> (target_q != '0))
		else $error("playing with zero period target");

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!playing_q |-> (phase_q == '0))
		else $error("phase counter moved while idle");

	a_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !div_busy)
		else $error("transaction accepted during divide");

endmodule

>>> hw/rtl/pts_ctrl.sv
// pts_ctrl: controller state machine - input handshake, note load sequencing,
// result valid register. Depends on pts_pkg.
module pts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  pts_pkg::dp_status_t status,
	output pts_pkg::dp_cmd_t    cmd
);
	import pts_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.need_load ? ST_FETCH : ST_EMIT;
				end
			end
			ST_FETCH: begin
				state_d = status.note_end ? ST_EMIT : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_FETCH:  cmd.fetch = 1'b1;
			ST_DIVIDE: cmd.load  = status.div_done;
			ST_EMIT:   cmd.emit  = out_free;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("result valid without emit");

	a_divide_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |=> (state_q == ST_DIVIDE || state_q == ST_EMIT))
		else $error("bad exit from divide");

	a_fetch_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q != ST_FETCH))
		else $error("fetch held for more than one cycle");

endmodule

>>> hw/rtl/pwm_tone_sequencer.sv
// pwm_tone_sequencer: top level of the buzzer tone sequencer.
// Instantiates pts_ctrl and pts_dp; depends on pts_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, opcode, pattern_select): opcode 1 starts
//   the ROM pattern picked by pattern_select unless one is playing; opcode 0 is
//   one buzzer timer tick. Every input transaction yields exactly one result
//   transaction (pin_level, busy_res, note_position) showing the state after it.
//   Configuration: cfg_we writes cfg_wdata into the tick rate register (Hz);
//   write only while the block is idle.
//   Sequencing: a transaction that loads no note goes from acceptance to the
//   emit state and then to the result register. One that starts a note adds a
//   ROM fetch and the serial divide that sets the period; a pattern end found
//   at fetch skips the divide. One transaction is in flight at a time.
//   The next transaction is taken while an earlier result is still held in the
//   output register; it waits at the end for that register to drain.
//   Receiver stall: the result register holds its value until taken.
//   Reset: tick rate returns to 375000, sequencer idle, pin low, no result.
module pwm_tone_sequencer #(
	parameter int PERIOD_WIDTH = pts_pkg::PERIOD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pts_pkg::RATE_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [pts_pkg::PAT_W-1:0]  pattern_select,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       pin_level,
	output logic                       busy_res,
	output logic [pts_pkg::NOTE_W-1:0] note_position
);
	import pts_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pts_dp #(
		.PERIOD_WIDTH (PERIOD_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.opcode         (opcode),
		.pattern_select (pattern_select),
		.cmd            (cmd),
		.status         (status),
		.pin_level      (pin_level),
		.busy_res       (busy_res),
		.note_position  (note_position)
	);

endmodule
